@@ rtl/ceu_pkg.sv @@
// Shared types, constants and helpers of the 8-bit CPU execute unit.
// Operation codes, the decoded item carried between front and back, and the result record.
// No dependencies.
package ceu_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
		OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
		OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
		OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
		OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
		OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
		OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_LDA = 6'd27,
		OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_NOP = 6'd31,
		OP_ORA = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_SBC = 6'd35,
		OP_SEC = 6'd36, OP_SED = 6'd37, OP_SEI = 6'd38, OP_STA = 6'd39,
		OP_STX = 6'd40, OP_STY = 6'd41, OP_TAX = 6'd42, OP_TAY = 6'd43,
		OP_TSX = 6'd44, OP_TXA = 6'd45, OP_TXS = 6'd46, OP_TYA = 6'd47
	} op_t;

	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_ONE = 5;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic [7:0]  STATUS_RESET = 8'h24;
	localparam logic [7:0]  STACK_RESET  = 8'hFD;
	localparam logic [15:0] BRK_VECTOR   = 16'hFFFE;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		op_t         op;
		logic [7:0]  opnd;
		logic [7:0]  alu_opnd;
		logic [15:0] pc;
		logic        to_mem;
		logic [1:0]  base_cost;
		logic [15:0] br_target;
		logic        br_cross;
	} ceu_item_t;

	typedef struct packed {
		logic [7:0]  store_data;
		logic        store_enable;
		logic [15:0] next_pc;
		logic [1:0]  cycle_cost;
		logic [7:0]  status_out;
		logic [7:0]  acc_out;
	} ceu_result_t;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[FLAG_N] = v[7];
		r[FLAG_Z] = (v == 8'h00);
		return r;
	endfunction

endpackage

@@ rtl/ceu_front.sv @@
// Front end of the execute unit: accepts input transactions and classifies them.
// Precomputes cost, branch target, page crossing and ALU operand. Depends on ceu_pkg.
module ceu_front import ceu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [5:0]  action,
	input  logic [7:0]  operand_byte,
	input  logic [15:0] next_instr_addr,
	input  logic        target_memory,
	output logic        item_valid,
	output ceu_item_t   item,
	input  logic        item_ready
);

	ceu_item_t dec;
	logic      valid_s1;
	ceu_item_t item_s1;
	logic      accept;
	op_t       op;

	assign op = op_t'(action);

	always_comb begin
		dec.op        = op;
		dec.opnd      = operand_byte;
		dec.alu_opnd  = (op == OP_SBC) ? ~operand_byte : operand_byte;
		dec.pc        = next_instr_addr;
		dec.to_mem    = target_memory;
		dec.br_target = next_instr_addr + {{8{operand_byte[7]}}, operand_byte};
		dec.br_cross  = (dec.br_target[15:8] != next_instr_addr[15:8]);
		unique case (op)
			OP_BRK: dec.base_cost = 2'd3;
			OP_ASL, OP_LSR, OP_ROL, OP_ROR,
			OP_CLC, OP_CLD, OP_CLI, OP_CLV,
			OP_SEC, OP_SED, OP_SEI,
			OP_DEC, OP_DEX, OP_DEY, OP_INC, OP_INX, OP_INY,
			OP_NOP,
			OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA: dec.base_cost = 2'd2;
			default: dec.base_cost = 2'd1;
		endcase
	end

	assign full   = valid_s1 && !item_ready;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !item_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= dec;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

@@ rtl/ceu_queue.sv @@
// Short queue of decoded items between the front and back ends.
// Register-based, depth QDEPTH. Depends on ceu_pkg.
module ceu_queue import ceu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ceu_item_t in_item,
	output logic      in_ready,
	output logic      out_valid,
	output ceu_item_t out_item,
	input  logic      out_take
);

	ceu_item_t          slot_q [QDEPTH];
	logic [QAW-1:0]     wr_q;
	logic [QAW-1:0]     rd_q;
	logic [QCW-1:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign in_ready  = (count_q != QCW'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = slot_q[rd_q];
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_take && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= in_item;
		end
	end

endmodule

@@ rtl/ceu_back.sv @@
// Back end of the execute unit: holds A, X, Y, S and P and executes one item per cycle
// while its output stage is free or popped, registering each result there. Depends on ceu_pkg.
module ceu_back import ceu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  ceu_item_t   in_item,
	output logic        in_take,
	output logic        empty,
	input  logic        pop,
	output ceu_result_t res
);

	logic [7:0]  a_q, x_q, y_q, s_q, p_q;
	logic [7:0]  a_n, x_n, y_n, s_n, p_n;
	logic        res_valid_s2;
	ceu_result_t res_s2;
	ceu_result_t res_n;
	logic        fire;

	logic [8:0]  sum;
	logic [7:0]  ovf;
	logic [7:0]  cmp_reg;
	logic [8:0]  cmp_diff;
	logic [7:0]  sv;
	logic [7:0]  sr;
	logic        shc;
	logic        shift;
	logic        taken;
	logic [7:0]  sdata;
	logic        sen;
	logic [15:0] npc;
	logic [1:0]  cost;

	assign fire    = in_valid && (!res_valid_s2 || pop);
	assign in_take = fire;
	assign empty   = !res_valid_s2;
	assign res     = res_s2;

	assign sum      = {1'b0, a_q} + {1'b0, in_item.alu_opnd} + {8'h00, p_q[FLAG_C]};
	assign ovf      = (sum[7:0] ^ a_q) & (sum[7:0] ^ in_item.alu_opnd);
	assign cmp_reg  = (in_item.op == OP_CPX) ? x_q : ((in_item.op == OP_CPY) ? y_q : a_q);
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, in_item.opnd};
	assign sv       = in_item.to_mem ? in_item.opnd : a_q;

	always_comb begin
		a_n   = a_q;
		x_n   = x_q;
		y_n   = y_q;
		s_n   = s_q;
		p_n   = p_q;
		sdata = 8'h00;
		sen   = 1'b0;
		npc   = in_item.pc;
		cost  = in_item.base_cost;
		shift = 1'b0;
		sr    = 8'h00;
		shc   = 1'b0;
		taken = 1'b0;
		unique case (in_item.op)
			OP_ADC, OP_SBC: begin
				a_n = sum[7:0];
				p_n[FLAG_V] = ovf[7];
				p_n[FLAG_C] = sum[8];
				p_n = set_nz(p_n, sum[7:0]);
			end
			OP_AND: begin
				a_n = a_q & in_item.opnd;
				p_n = set_nz(p_q, a_q & in_item.opnd);
			end
			OP_ORA: begin
				a_n = a_q | in_item.opnd;
				p_n = set_nz(p_q, a_q | in_item.opnd);
			end
			OP_EOR: begin
				a_n = a_q ^ in_item.opnd;
				p_n = set_nz(p_q, a_q ^ in_item.opnd);
			end
			OP_ASL: begin
				shift = 1'b1; shc = sv[7]; sr = {sv[6:0], 1'b0};
			end
			OP_LSR: begin
				shift = 1'b1; shc = sv[0]; sr = {1'b0, sv[7:1]};
			end
			OP_ROL: begin
				shift = 1'b1; shc = sv[7]; sr = {sv[6:0], p_q[FLAG_C]};
			end
			OP_ROR: begin
				shift = 1'b1; shc = sv[0]; sr = {p_q[FLAG_C], sv[7:1]};
			end
			OP_BCC: taken = !p_q[FLAG_C];
			OP_BCS: taken = p_q[FLAG_C];
			OP_BEQ: taken = p_q[FLAG_Z];
			OP_BNE: taken = !p_q[FLAG_Z];
			OP_BMI: taken = p_q[FLAG_N];
			OP_BPL: taken = !p_q[FLAG_N];
			OP_BVC: taken = !p_q[FLAG_V];
			OP_BVS: taken = p_q[FLAG_V];
			OP_BIT: begin
				p_n[FLAG_N] = in_item.opnd[7];
				p_n[FLAG_V] = in_item.opnd[6];
				p_n[FLAG_Z] = ((a_q & in_item.opnd) == 8'h00);
			end
			OP_BRK: begin
				p_n[FLAG_I] = 1'b1;
				npc = BRK_VECTOR;
			end
			OP_CLC: p_n[FLAG_C] = 1'b0;
			OP_CLD: p_n[FLAG_D] = 1'b0;
			OP_CLI: p_n[FLAG_I] = 1'b0;
			OP_CLV: p_n[FLAG_V] = 1'b0;
			OP_SEC: p_n[FLAG_C] = 1'b1;
			OP_SED: p_n[FLAG_D] = 1'b1;
			OP_SEI: p_n[FLAG_I] = 1'b1;
			OP_CMP, OP_CPX, OP_CPY: begin
				p_n[FLAG_C] = !cmp_diff[8];
				p_n = set_nz(p_n, cmp_diff[7:0]);
			end
			OP_DEC: begin
				sdata = in_item.opnd - 8'd1;
				sen = 1'b1;
				p_n = set_nz(p_q, in_item.opnd - 8'd1);
			end
			OP_INC: begin
				sdata = in_item.opnd + 8'd1;
				sen = 1'b1;
				p_n = set_nz(p_q, in_item.opnd + 8'd1);
			end
			OP_DEX: begin
				x_n = x_q - 8'd1;
				p_n = set_nz(p_q, x_q - 8'd1);
			end
			OP_DEY: begin
				y_n = y_q - 8'd1;
				p_n = set_nz(p_q, y_q - 8'd1);
			end
			OP_INX: begin
				x_n = x_q + 8'd1;
				p_n = set_nz(p_q, x_q + 8'd1);
			end
			OP_INY: begin
				y_n = y_q + 8'd1;
				p_n = set_nz(p_q, y_q + 8'd1);
			end
			OP_LDA: begin
				a_n = in_item.opnd;
				p_n = set_nz(p_q, in_item.opnd);
			end
			OP_LDX: begin
				x_n = in_item.opnd;
				p_n = set_nz(p_q, in_item.opnd);
			end
			OP_LDY: begin
				y_n = in_item.opnd;
				p_n = set_nz(p_q, in_item.opnd);
			end
			OP_STA: begin
				sdata = a_q; sen = 1'b1;
			end
			OP_STX: begin
				sdata = x_q; sen = 1'b1;
			end
			OP_STY: begin
				sdata = y_q; sen = 1'b1;
			end
			OP_TAX: begin
				x_n = a_q; p_n = set_nz(p_q, a_q);
			end
			OP_TAY: begin
				y_n = a_q; p_n = set_nz(p_q, a_q);
			end
			OP_TSX: begin
				x_n = s_q; p_n = set_nz(p_q, s_q);
			end
			OP_TXA: begin
				a_n = x_q; p_n = set_nz(p_q, x_q);
			end
			OP_TYA: begin
				a_n = y_q; p_n = set_nz(p_q, y_q);
			end
			OP_TXS: s_n = x_q;
			default: ;
		endcase
		if (shift) begin
			p_n[FLAG_C] = shc;
			p_n = set_nz(p_n, sr);
			if (in_item.to_mem) begin
				sdata = sr;
				sen = 1'b1;
			end else begin
				a_n = sr;
			end
		end
		if (taken) begin
			npc = in_item.br_target;
			cost = in_item.br_cross ? 2'd3 : 2'd2;
		end
		res_n.store_data   = sdata;
		res_n.store_enable = sen;
		res_n.next_pc      = npc;
		res_n.cycle_cost   = cost;
		res_n.status_out   = p_n;
		res_n.acc_out      = a_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q          <= 8'h00;
			x_q          <= 8'h00;
			y_q          <= 8'h00;
			s_q          <= STACK_RESET;
			p_q          <= STATUS_RESET;
			res_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				a_q <= a_n;
				x_q <= x_n;
				y_q <= y_n;
				s_q <= s_n;
				p_q <= p_n;
			end
			res_valid_s2 <= fire || (res_valid_s2 && !pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_status_one: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[FLAG_ONE])
		else $error("status bit 5 cleared");
	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && !res_s2.store_enable |-> res_s2.store_data == 8'h00)
		else $error("store data without store enable");
	a_cost_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> res_s2.cycle_cost != 2'd0)
		else $error("zero cycle cost reported");
	a_acc_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_s2.acc_out == a_q && res_s2.status_out == p_q)
		else $error("result disagrees with architectural state");
`endif

endmodule

@@ rtl/cpu_8bit_execute_unit.sv @@
// Top level of the 8-bit CPU execute unit: front end, item queue and back end.
// Depends on ceu_pkg, ceu_front, ceu_queue and ceu_back.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------------------
//   input    | push / full       | action, operand_byte, next_instr_addr, target_memory
//   result   | empty / pop       | store_data, store_enable, next_pc, cycle_cost,
//            |                   | status_out, acc_out
//
// One transaction per cycle sustained while results are popped; a push reaches the result
// ports through the front register, the queue and the back output register.
// Registers and flags update in the single back-end execute step.
// Reset empties the front register, queue and output stage; A, X, Y are 0, S is 0xFD, P is 0x24.
// A stalled result holds the back end; the queue and front register absorb input until full.
module cpu_8bit_execute_unit import ceu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [5:0]  action,
	input  logic [7:0]  operand_byte,
	input  logic [15:0] next_instr_addr,
	input  logic        target_memory,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  store_data,
	output logic        store_enable,
	output logic [15:0] next_pc,
	output logic [1:0]  cycle_cost,
	output logic [7:0]  status_out,
	output logic [7:0]  acc_out
);

	logic        f_valid;
	ceu_item_t   f_item;
	logic        f_ready;
	logic        q_valid;
	ceu_item_t   q_item;
	logic        q_take;
	ceu_result_t res;

	ceu_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.action          (action),
		.operand_byte    (operand_byte),
		.next_instr_addr (next_instr_addr),
		.target_memory   (target_memory),
		.item_valid      (f_valid),
		.item            (f_item),
		.item_ready      (f_ready)
	);

	ceu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.in_ready  (f_ready),
		.out_valid (q_valid),
		.out_item  (q_item),
		.out_take  (q_take)
	);

	ceu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.in_take  (q_take),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	assign store_data   = res.store_data;
	assign store_enable = res.store_enable;
	assign next_pc      = res.next_pc;
	assign cycle_cost   = res.cycle_cost;
	assign status_out   = res.status_out;
	assign acc_out      = res.acc_out;

endmodule
